[rtl/sdspi_pkg.sv]
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types, codes and CRC helpers for the SD card SPI-mode sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  // Item commands carried on the input channel.
  typedef enum logic [1:0] {
    CMD_PLAIN = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_XCHG  = 2'd3
  } cmd_t;

  // Completion status reported with done_res.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_RESP  = 3'd1,
    ST_NO_TOKEN = 3'd2,
    ST_CRC_ERR  = 3'd3,
    ST_REJECTED = 3'd4
  } status_t;

  // Sequencer phases, one-hot.
  typedef enum logic [10:0] {
    PH_IDLE      = 11'b000_0000_0001,
    PH_CMD       = 11'b000_0000_0010,
    PH_RESP      = 11'b000_0000_0100,
    PH_RESP_MORE = 11'b000_0000_1000,
    PH_TOKEN     = 11'b000_0001_0000,
    PH_DATA_IN   = 11'b000_0010_0000,
    PH_CRC_IN    = 11'b000_0100_0000,
    PH_DATA_OUT  = 11'b000_1000_0000,
    PH_CRC_OUT   = 11'b001_0000_0000,
    PH_DRESP     = 11'b010_0000_0000,
    PH_BUSY      = 11'b100_0000_0000
  } phase_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CLOCK_FAST     = 2'd0;
  localparam logic [1:0] CFG_RESPONSE_TRIES = 2'd1;
  localparam logic [1:0] CFG_TOKEN_TRIES    = 2'd2;

  localparam logic [7:0]  BYTE_IDLE        = 8'hFF;
  localparam logic [7:0]  BYTE_START_TOKEN = 8'hFE;
  localparam logic [7:0]  BYTE_BUSY        = 8'h00;
  localparam logic [4:0]  DRESP_MASK_OK    = 5'h05;
  localparam logic [1:0]  CMD_PREFIX       = 2'b01;
  localparam logic [7:0]  RESP_TRIES_RST   = 8'd8;
  localparam logic [11:0] TOKEN_TRIES_RST  = 12'd2048;

  localparam logic [6:0]  CRC7_POLY  = 7'h09;
  localparam logic [15:0] CRC16_POLY = 16'h1021;

  function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] b);
    logic [6:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[6] ^ b[i];
      c  = {c[5:0], 1'b0} ^ (fb ? CRC7_POLY : 7'h00);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC16_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

[rtl/sd_spi_transaction_engine.sv]
// ----------------------------------------------------------------------------
// sd_spi_transaction_engine
// SD card SPI-mode transaction sequencer: plain command, block read, block write.
// ----------------------------------------------------------------------------
// Each accepted item's result is written into the output register as it is taken.
// Throughput: one item per cycle unless the result side stalls; the byte-wide CRC7/CRC16
// updates are combinational logic between the item inputs and the result register.
// in_ready stays high while the result register is empty or being taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle, clears the result
// valid flag and loads the configuration defaults: slow clock, 8 and 2048 tries.
module sd_spi_transaction_engine #(
  parameter int MAX_BLOCK = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [11:0]          cfg_data,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  sdspi_pkg::cmd_t      in_command,
  input  logic [5:0]           in_cmd_index,
  input  logic [31:0]          in_argument,
  input  logic [2:0]           in_response_length,
  input  logic [9:0]           in_block_length,
  input  logic [7:0]           in_miso_byte,
  input  logic [7:0]           in_write_byte,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_mosi_byte,
  output logic                 out_send_valid,
  output logic                 out_chip_select,
  output logic                 out_spi_clock_fast,
  output logic [7:0]           out_resp_byte,
  output logic                 out_resp_valid,
  output logic [7:0]           out_read_byte,
  output logic                 out_read_valid,
  output logic                 out_data_wanted,
  output logic                 out_done_res,
  output sdspi_pkg::status_t   out_status
);
  import sdspi_pkg::*;

  // The byte counter must reach the block length and also count the six
  // command bytes and up to five response bytes.
  localparam int LCLOG = $clog2(MAX_BLOCK + 1);
  localparam int BCW   = (LCLOG < 3) ? 3 : LCLOG;
  localparam logic [10:0]    MAX_BLK11 = 11'(MAX_BLOCK);
  localparam logic [BCW-1:0] MAX_BLK_BC = BCW'(MAX_BLOCK);
  localparam logic [BCW-1:0] BC_ONE   = BCW'(1);
  localparam logic [BCW-1:0] BC_TWO   = BCW'(2);
  localparam logic [BCW-1:0] BC_FIVE  = BCW'(5);
  localparam logic [BCW-1:0] BC_SIX   = BCW'(6);

  // Configuration registers.
  logic        clock_fast_r;
  logic [7:0]  response_tries_r;
  logic [11:0] token_tries_r;

  // Sequencer state.
  phase_t          phase_r, phase_nxt;
  logic [1:0]      transaction_kind_r, transaction_kind_nxt;
  logic [39:0]     command_shift_r, command_shift_nxt;
  logic [BCW-1:0]  byte_count_r, byte_count_nxt;
  logic [11:0]     try_count_r, try_count_nxt;
  logic [6:0]      crc7_r, crc7_nxt;
  logic [15:0]     crc16_r, crc16_nxt;
  logic [BCW-1:0]  length_latch_r, length_latch_nxt;

  // Result register.
  logic        out_valid_r;
  logic [7:0]  mosi_r, mosi_nxt;
  logic        send_r, send_nxt;
  logic        cs_r, cs_nxt;
  logic        fast_r;
  logic [7:0]  resp_byte_r, resp_byte_nxt;
  logic        resp_valid_r, resp_valid_nxt;
  logic [7:0]  read_byte_r, read_byte_nxt;
  logic        read_valid_r, read_valid_nxt;
  logic        data_wanted_r, data_wanted_nxt;
  logic        done_r, done_nxt;
  status_t     status_r, status_nxt;

  logic in_fire;

  // The result register is a one-deep output stage: a new item is taken
  // whenever the held result is empty or leaves in the same cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Configuration writes; indexes past the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_fast_r     <= 1'b0;
      response_tries_r <= RESP_TRIES_RST;
      token_tries_r    <= TOKEN_TRIES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLOCK_FAST:     clock_fast_r     <= cfg_data[0];
        CFG_RESPONSE_TRIES: response_tries_r <= cfg_data[7:0];
        CFG_TOKEN_TRIES:    token_tries_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state and result for the item on the input ports.
  always_comb begin
    logic [7:0]     rt;
    logic [11:0]    tt;
    logic [11:0]    try_inc;
    logic [BCW-1:0] bc_inc;
    logic [15:0]    crc16_upd;
    logic [7:0]     cmd_b;

    // A zero try limit behaves like a limit of one.
    rt      = (response_tries_r == 8'd0) ? 8'd1 : response_tries_r;
    tt      = (token_tries_r == 12'd0) ? 12'd1 : token_tries_r;
    try_inc = try_count_r + 12'd1;
    bc_inc  = byte_count_r + BC_ONE;
    crc16_upd = crc16_byte(crc16_r, in_miso_byte);
    cmd_b   = {CMD_PREFIX, in_cmd_index};

    phase_nxt            = phase_r;
    transaction_kind_nxt = transaction_kind_r;
    command_shift_nxt    = command_shift_r;
    byte_count_nxt       = byte_count_r;
    try_count_nxt        = try_count_r;
    crc7_nxt             = crc7_r;
    crc16_nxt            = crc16_r;
    length_latch_nxt     = length_latch_r;

    mosi_nxt        = BYTE_IDLE;
    send_nxt        = 1'b0;
    cs_nxt          = 1'b0;
    resp_byte_nxt   = 8'h00;
    resp_valid_nxt  = 1'b0;
    read_byte_nxt   = 8'h00;
    read_valid_nxt  = 1'b0;
    data_wanted_nxt = 1'b0;
    done_nxt        = 1'b0;
    status_nxt      = ST_OK;

    if (in_command != CMD_XCHG) begin
      // A start item always begins a new transaction, abandoning any other.
      transaction_kind_nxt = in_command;
      command_shift_nxt    = {in_argument, 8'h00};
      if (in_command == CMD_PLAIN) begin
        if (in_response_length == 3'd0) begin
          length_latch_nxt = BC_ONE;
        end else if (in_response_length > 3'd5) begin
          length_latch_nxt = BC_FIVE;
        end else begin
          length_latch_nxt = BCW'(in_response_length);
        end
      end else begin
        if (in_block_length == 10'd0) begin
          length_latch_nxt = BC_ONE;
        end else if ({1'b0, in_block_length} > MAX_BLK11) begin
          length_latch_nxt = MAX_BLK_BC;
        end else begin
          length_latch_nxt = BCW'(in_block_length);
        end
      end
      crc7_nxt       = crc7_byte(7'd0, cmd_b);
      crc16_nxt      = 16'h0000;
      try_count_nxt  = 12'd0;
      byte_count_nxt = BC_ONE;
      phase_nxt      = PH_CMD;
      mosi_nxt       = cmd_b;
      send_nxt       = 1'b1;
      cs_nxt         = 1'b1;
    end else begin
      // Most branches ask for another selected 0xFF poll; those that
      // finish overwrite this with the deselected trailing byte.
      send_nxt = 1'b1;
      cs_nxt   = 1'b1;
      case (phase_r)
        PH_CMD: begin
          if (byte_count_r < BC_FIVE) begin
            mosi_nxt          = command_shift_r[39:32];
            crc7_nxt          = crc7_byte(crc7_r, command_shift_r[39:32]);
            command_shift_nxt = {command_shift_r[31:0], 8'h00};
            byte_count_nxt    = bc_inc;
          end else if (byte_count_r == BC_FIVE) begin
            byte_count_nxt = BC_SIX;
            mosi_nxt       = {crc7_r, 1'b1};
          end else begin
            try_count_nxt = 12'd0;
            phase_nxt     = PH_RESP;
          end
        end
        PH_RESP: begin
          if (in_miso_byte != BYTE_IDLE) begin
            resp_byte_nxt  = in_miso_byte;
            resp_valid_nxt = 1'b1;
            case (transaction_kind_r)
              CMD_PLAIN: begin
                if (length_latch_r <= BC_ONE) begin
                  cs_nxt     = 1'b0;
                  done_nxt   = 1'b1;
                  status_nxt = ST_OK;
                  phase_nxt  = PH_IDLE;
                end else begin
                  byte_count_nxt = BC_ONE;
                  phase_nxt      = PH_RESP_MORE;
                end
              end
              CMD_READ: begin
                try_count_nxt = 12'd0;
                phase_nxt     = PH_TOKEN;
              end
              default: begin
                crc16_nxt       = 16'h0000;
                byte_count_nxt  = '0;
                phase_nxt       = PH_DATA_OUT;
                mosi_nxt        = BYTE_START_TOKEN;
                data_wanted_nxt = 1'b1;
              end
            endcase
          end else begin
            try_count_nxt = try_inc;
            if (try_inc >= {4'd0, rt}) begin
              cs_nxt     = 1'b0;
              done_nxt   = 1'b1;
              status_nxt = ST_NO_RESP;
              phase_nxt  = PH_IDLE;
            end
          end
        end
        PH_RESP_MORE: begin
          resp_byte_nxt  = in_miso_byte;
          resp_valid_nxt = 1'b1;
          byte_count_nxt = bc_inc;
          if (bc_inc >= length_latch_r) begin
            cs_nxt     = 1'b0;
            done_nxt   = 1'b1;
            status_nxt = ST_OK;
            phase_nxt  = PH_IDLE;
          end
        end
        PH_TOKEN: begin
          if (in_miso_byte == BYTE_START_TOKEN) begin
            crc16_nxt      = 16'h0000;
            byte_count_nxt = '0;
            phase_nxt      = PH_DATA_IN;
          end else begin
            try_count_nxt = try_inc;
            if (try_inc >= tt) begin
              cs_nxt     = 1'b0;
              done_nxt   = 1'b1;
              status_nxt = ST_NO_TOKEN;
              phase_nxt  = PH_IDLE;
            end
          end
        end
        PH_DATA_IN: begin
          read_byte_nxt  = in_miso_byte;
          read_valid_nxt = 1'b1;
          crc16_nxt      = crc16_upd;
          if (bc_inc >= length_latch_r) begin
            byte_count_nxt = '0;
            phase_nxt      = PH_CRC_IN;
          end else begin
            byte_count_nxt = bc_inc;
          end
        end
        PH_CRC_IN: begin
          // Running the CRC over the received CRC bytes leaves zero if good.
          crc16_nxt      = crc16_upd;
          byte_count_nxt = bc_inc;
          if (bc_inc >= BC_TWO) begin
            cs_nxt     = 1'b0;
            done_nxt   = 1'b1;
            status_nxt = (crc16_upd == 16'h0000) ? ST_OK : ST_CRC_ERR;
            phase_nxt  = PH_IDLE;
          end
        end
        PH_DATA_OUT: begin
          if (byte_count_r < length_latch_r) begin
            crc16_nxt       = crc16_byte(crc16_r, in_write_byte);
            byte_count_nxt  = bc_inc;
            mosi_nxt        = in_write_byte;
            data_wanted_nxt = (bc_inc < length_latch_r);
          end else begin
            byte_count_nxt = '0;
            phase_nxt      = PH_CRC_OUT;
            mosi_nxt       = crc16_r[15:8];
          end
        end
        PH_CRC_OUT: begin
          if (byte_count_r == '0) begin
            byte_count_nxt = BC_ONE;
            mosi_nxt       = crc16_r[7:0];
          end else begin
            phase_nxt = PH_DRESP;
          end
        end
        PH_DRESP: begin
          if (in_miso_byte != BYTE_IDLE) begin
            resp_byte_nxt  = in_miso_byte;
            resp_valid_nxt = 1'b1;
            if (in_miso_byte[4:0] != DRESP_MASK_OK) begin
              cs_nxt     = 1'b0;
              done_nxt   = 1'b1;
              status_nxt = ST_REJECTED;
              phase_nxt  = PH_IDLE;
            end else begin
              phase_nxt = PH_BUSY;
            end
          end
        end
        PH_BUSY: begin
          // The card holds the line low while it programs the block.
          if (in_miso_byte != BYTE_BUSY) begin
            cs_nxt     = 1'b0;
            done_nxt   = 1'b1;
            status_nxt = ST_OK;
            phase_nxt  = PH_IDLE;
          end
        end
        default: begin
          // Exchange while idle is answered with an empty result.
          send_nxt  = 1'b0;
          cs_nxt    = 1'b0;
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Sequencer state and result register, updated on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= PH_IDLE;
      transaction_kind_r <= 2'd0;
      command_shift_r    <= '0;
      byte_count_r       <= '0;
      try_count_r        <= '0;
      crc7_r             <= '0;
      crc16_r            <= '0;
      length_latch_r     <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r            <= phase_nxt;
        transaction_kind_r <= transaction_kind_nxt;
        command_shift_r    <= command_shift_nxt;
        byte_count_r       <= byte_count_nxt;
        try_count_r        <= try_count_nxt;
        crc7_r             <= crc7_nxt;
        crc16_r            <= crc16_nxt;
        length_latch_r     <= length_latch_nxt;
        out_valid_r        <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload carries no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mosi_r        <= mosi_nxt;
      send_r        <= send_nxt;
      cs_r          <= cs_nxt;
      fast_r        <= clock_fast_r;
      resp_byte_r   <= resp_byte_nxt;
      resp_valid_r  <= resp_valid_nxt;
      read_byte_r   <= read_byte_nxt;
      read_valid_r  <= read_valid_nxt;
      data_wanted_r <= data_wanted_nxt;
      done_r        <= done_nxt;
      status_r      <= status_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mosi_byte      = mosi_r;
  assign out_send_valid     = send_r;
  assign out_chip_select    = cs_r;
  assign out_spi_clock_fast = fast_r;
  assign out_resp_byte      = resp_byte_r;
  assign out_resp_valid     = resp_valid_r;
  assign out_read_byte      = read_byte_r;
  assign out_read_valid     = read_valid_r;
  assign out_data_wanted    = data_wanted_r;
  assign out_done_res       = done_r;
  assign out_status         = status_r;

  // A finished transaction always asks for the deselected trailing byte.
  a_done_deselects: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> !cs_r && send_r && phase_r == PH_IDLE)
    else $error("done result without deselect and trailing byte");

  // An error status appears only together with the end of a transaction.
  a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !done_r |-> status_r == ST_OK)
    else $error("status set on a result that does not end the transaction");

  // Response bytes and read data never share one result.
  a_resp_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(resp_valid_r && read_valid_r))
    else $error("response and read data flagged in the same result");

  // A data request is only made while the write data phase is running.
  a_data_wanted_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && data_wanted_r |-> phase_r == PH_DATA_OUT)
    else $error("write data requested outside the data phase");

  // A response poll that reaches the response try limit returns the sequencer to idle.
  a_try_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_RESP && in_command == CMD_XCHG
      && in_miso_byte == BYTE_IDLE && try_count_r + 12'd1 >= {4'd0, response_tries_r}
      && response_tries_r != 8'd0 |=> phase_r == PH_IDLE)
    else $error("response poll did not time out at its limit");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SD card SPI-mode transaction sequencer. A
// behavioral card answers most exchanges from the predicted sequencer phase,
// so most transactions run to completion. Errors, timeouts and abandoned
// transactions are injected on top. Every result is checked against a
// cycle-free model of the sequencer that is kept inside a scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdspi_pkg::*;

  localparam int MAX_BLOCK   = 512;
  localparam int ITEM_GOAL   = 1300;
  localparam int CYCLE_LIMIT = 500000;

  // One input item: a start or an exchange, with every field of the channel.
  typedef struct packed {
    cmd_t        command;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [2:0]  rlen;
    logic [9:0]  blen;
    logic [7:0]  miso;
    logic [7:0]  wbyte;
  } item_t;

  // One result item, field for field as it leaves the block.
  typedef struct packed {
    logic [7:0] mosi;
    logic       send;
    logic       cs;
    logic       fast;
    logic [7:0] resp;
    logic       resp_v;
    logic [7:0] rd;
    logic       rd_v;
    logic       want;
    logic       done;
    status_t    status;
  } result_t;

  // Faults that the card model can put into a transaction.
  typedef enum int {
    F_NONE,
    F_NO_RESP,
    F_NO_TOKEN,
    F_BAD_CRC,
    F_REJECT
  } fault_t;

  // Scoreboard: keeps its own copy of the sequencer state and registers,
  // predicts the result of every accepted item and checks results in order.
  class sd_seq_scoreboard;
    logic        clk_fast;
    logic [7:0]  resp_tries;
    logic [11:0] token_tries;

    phase_t      phase;
    cmd_t        kind;
    logic [39:0] cmd_word;
    logic [9:0]  count;
    logic [11:0] tries;
    logic [6:0]  crc7;
    logic [15:0] crc16;
    logic [9:0]  length;

    result_t     nxt;
    result_t     expected_q[$];
    int          errors;
    int          reported;
    int          results_seen;
    int          endings[5];

    function new();
      clk_fast    = 1'b0;
      resp_tries  = RESP_TRIES_RST;
      token_tries = TOKEN_TRIES_RST;
      phase       = PH_IDLE;
      kind        = CMD_PLAIN;
      cmd_word    = '0;
      count       = '0;
      tries       = '0;
      crc7        = '0;
      crc16       = '0;
      length      = '0;
      errors       = 0;
      reported     = 0;
      results_seen = 0;
      foreach (endings[i]) endings[i] = 0;
    endfunction

    function logic [6:0] crc7_next(logic [6:0] c, logic [7:0] d);
      for (int i = 7; i >= 0; i--)
        c = (c[6] ^ d[i]) ? ({c[5:0], 1'b0} ^ 7'h09) : {c[5:0], 1'b0};
      return c;
    endfunction

    function logic [15:0] crc16_next(logic [15:0] c, logic [7:0] d);
      for (int i = 7; i >= 0; i--)
        c = (c[15] ^ d[i]) ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      return c;
    endfunction

    function void set_reg(logic [1:0] idx, logic [11:0] data);
      case (idx)
        CFG_CLOCK_FAST:     clk_fast = data[0];
        CFG_RESPONSE_TRIES: resp_tries = data[7:0];
        CFG_TOKEN_TRIES:    token_tries = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // A byte sent with the card selected.
    function void drive(logic [7:0] b);
      nxt.mosi = b;
      nxt.send = 1'b1;
      nxt.cs   = 1'b1;
    endfunction

    // End of a transaction: deselect and ask for the trailing idle byte.
    function void close(status_t st);
      nxt.mosi   = BYTE_IDLE;
      nxt.send   = 1'b1;
      nxt.cs     = 1'b0;
      nxt.done   = 1'b1;
      nxt.status = st;
      phase      = PH_IDLE;
      endings[st]++;
    endfunction

    function void response_taken();
      if (kind == CMD_PLAIN) begin
        if (length <= 1) begin
          close(ST_OK);
        end else begin
          count = 1;
          phase = PH_RESP_MORE;
          drive(BYTE_IDLE);
        end
      end else if (kind == CMD_READ) begin
        tries = '0;
        phase = PH_TOKEN;
        drive(BYTE_IDLE);
      end else begin
        crc16 = '0;
        count = '0;
        phase = PH_DATA_OUT;
        drive(BYTE_START_TOKEN);
        nxt.want = 1'b1;
      end
    endfunction

    function void note_item(item_t it);
      logic [11:0] rt;
      logic [11:0] tt;
      logic [7:0]  b;
      nxt        = '0;
      nxt.mosi   = BYTE_IDLE;
      nxt.status = ST_OK;
      // A try register of zero acts as a single try.
      rt = (resp_tries == 8'd0) ? 12'd1 : {4'd0, resp_tries};
      tt = (token_tries == 12'd0) ? 12'd1 : token_tries;

      if (it.command != CMD_XCHG) begin
        // A start always wins, even over a transaction still running.
        kind     = it.command;
        cmd_word = {CMD_PREFIX, it.cmd_index, it.argument};
        if (it.command == CMD_PLAIN)
          length = (it.rlen == 3'd0) ? 10'd1 : (it.rlen > 3'd5) ? 10'd5 : {7'd0, it.rlen};
        else
          length = (it.blen == 10'd0) ? 10'd1 :
                   (it.blen > MAX_BLOCK) ? 10'(MAX_BLOCK) : it.blen;
        crc7  = crc7_next(7'd0, cmd_word[39:32]);
        crc16 = '0;
        tries = '0;
        count = 10'd1;
        phase = PH_CMD;
        drive(cmd_word[39:32]);
      end else begin
        case (phase)
          PH_CMD: begin
            if (count < 10'd5) begin
              b     = cmd_word[39 - 8 * count -: 8];
              crc7  = crc7_next(crc7, b);
              count = count + 1'b1;
              drive(b);
            end else if (count == 10'd5) begin
              count = 10'd6;
              drive({crc7, 1'b1});
            end else begin
              tries = '0;
              phase = PH_RESP;
              drive(BYTE_IDLE);
            end
          end
          PH_RESP: begin
            if (it.miso != BYTE_IDLE) begin
              nxt.resp   = it.miso;
              nxt.resp_v = 1'b1;
              response_taken();
            end else begin
              tries = tries + 1'b1;
              if (tries >= rt) close(ST_NO_RESP);
              else drive(BYTE_IDLE);
            end
          end
          PH_RESP_MORE: begin
            nxt.resp   = it.miso;
            nxt.resp_v = 1'b1;
            count = count + 1'b1;
            if (count >= length) close(ST_OK);
            else drive(BYTE_IDLE);
          end
          PH_TOKEN: begin
            if (it.miso == BYTE_START_TOKEN) begin
              crc16 = '0;
              count = '0;
              phase = PH_DATA_IN;
              drive(BYTE_IDLE);
            end else begin
              tries = tries + 1'b1;
              if (tries >= tt) close(ST_NO_TOKEN);
              else drive(BYTE_IDLE);
            end
          end
          PH_DATA_IN: begin
            nxt.rd   = it.miso;
            nxt.rd_v = 1'b1;
            crc16 = crc16_next(crc16, it.miso);
            count = count + 1'b1;
            if (count >= length) begin
              count = '0;
              phase = PH_CRC_IN;
            end
            drive(BYTE_IDLE);
          end
          PH_CRC_IN: begin
            crc16 = crc16_next(crc16, it.miso);
            count = count + 1'b1;
            if (count >= 10'd2) close((crc16 == 16'd0) ? ST_OK : ST_CRC_ERR);
            else drive(BYTE_IDLE);
          end
          PH_DATA_OUT: begin
            if (count < length) begin
              crc16 = crc16_next(crc16, it.wbyte);
              count = count + 1'b1;
              drive(it.wbyte);
              nxt.want = (count < length);
            end else begin
              count = '0;
              phase = PH_CRC_OUT;
              drive(crc16[15:8]);
            end
          end
          PH_CRC_OUT: begin
            if (count == 10'd0) begin
              count = 10'd1;
              drive(crc16[7:0]);
            end else begin
              phase = PH_DRESP;
              drive(BYTE_IDLE);
            end
          end
          PH_DRESP: begin
            if (it.miso == BYTE_IDLE) begin
              drive(BYTE_IDLE);
            end else begin
              nxt.resp   = it.miso;
              nxt.resp_v = 1'b1;
              if (it.miso[4:0] != DRESP_MASK_OK) begin
                close(ST_REJECTED);
              end else begin
                phase = PH_BUSY;
                drive(BYTE_IDLE);
              end
            end
          end
          PH_BUSY: begin
            if (it.miso == BYTE_BUSY) drive(BYTE_IDLE);
            else close(ST_OK);
          end
          default: phase = PH_IDLE;
        endcase
      end
      nxt.fast = clk_fast;
      expected_q.push_back(nxt);
    endfunction

    function string show(result_t r);
      return $sformatf({"mosi=%02h send=%0b cs=%0b fast=%0b resp=%02h/%0b ",
                        "read=%02h/%0b want=%0b done=%0b status=%0d"},
                       r.mosi, r.send, r.cs, r.fast, r.resp, r.resp_v,
                       r.rd, r.rd_v, r.want, r.done, r.status);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("[%0t] result with nothing expected: %s", $time, show(got));
        end
        return;
      end
      exp_r = expected_q.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("[%0t] mismatch on result %0d", $time, results_seen);
          $display("  expected %s", show(exp_r));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  cmd_t        in_command;
  logic [5:0]  in_cmd_index;
  logic [31:0] in_argument;
  logic [2:0]  in_response_length;
  logic [9:0]  in_block_length;
  logic [7:0]  in_miso_byte;
  logic [7:0]  in_write_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_mosi_byte;
  logic        out_send_valid;
  logic        out_chip_select;
  logic        out_spi_clock_fast;
  logic [7:0]  out_resp_byte;
  logic        out_resp_valid;
  logic [7:0]  out_read_byte;
  logic        out_read_valid;
  logic        out_data_wanted;
  logic        out_done_res;
  status_t     out_status;

  sd_seq_scoreboard sb;

  // When calm is set, neither side idles: a stretch at full rate.
  logic calm;
  int   cycle_count;
  int   n_items;
  int   n_idle;
  int   n_starts[3];

  sd_spi_transaction_engine #(.MAX_BLOCK(MAX_BLOCK)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_cmd_index      (in_cmd_index),
    .in_argument       (in_argument),
    .in_response_length(in_response_length),
    .in_block_length   (in_block_length),
    .in_miso_byte      (in_miso_byte),
    .in_write_byte     (in_write_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mosi_byte     (out_mosi_byte),
    .out_send_valid    (out_send_valid),
    .out_chip_select   (out_chip_select),
    .out_spi_clock_fast(out_spi_clock_fast),
    .out_resp_byte     (out_resp_byte),
    .out_resp_valid    (out_resp_valid),
    .out_read_byte     (out_read_byte),
    .out_read_valid    (out_read_valid),
    .out_data_wanted   (out_data_wanted),
    .out_done_res      (out_done_res),
    .out_status        (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The result side stalls with a chance of about 28 percent, except when calm.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 28);
  end

  // Every accepted result is checked against the oldest expectation. All
  // inputs change by nonblocking assignment, so the values seen here are the
  // ones that were present at the edge.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.mosi   = out_mosi_byte;
      got.send   = out_send_valid;
      got.cs     = out_chip_select;
      got.fast   = out_spi_clock_fast;
      got.resp   = out_resp_byte;
      got.resp_v = out_resp_valid;
      got.rd     = out_read_byte;
      got.rd_v   = out_read_valid;
      got.want   = out_data_wanted;
      got.done   = out_done_res;
      got.status = out_status;
      sb.check_result(got);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic item_t random_item();
    item_t it;
    it.command   = cmd_t'(2'($urandom_range(3)));
    it.cmd_index = 6'($urandom);
    it.argument  = $urandom;
    it.rlen      = 3'($urandom);
    it.blen      = 10'($urandom);
    it.miso      = 8'($urandom);
    it.wbyte     = 8'($urandom);
    return it;
  endfunction

  // Presents one item, holds it until accepted, then hands it to the
  // scoreboard in the same step. The card model reads the predicted phase
  // right after this returns, so prediction and stimulus stay in one process.
  task automatic send_item(input item_t it);
    if (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 28);
    end
    in_valid           <= 1'b1;
    in_command         <= it.command;
    in_cmd_index       <= it.cmd_index;
    in_argument        <= it.argument;
    in_response_length <= it.rlen;
    in_block_length    <= it.blen;
    in_miso_byte       <= it.miso;
    in_write_byte      <= it.wbyte;
    do @(posedge clk); while (!in_ready);
    if (it.command == CMD_XCHG && sb.phase == PH_IDLE) begin
      n_idle++;
    end else begin
      n_items++;
      if (it.command != CMD_XCHG) n_starts[it.command]++;
    end
    sb.note_item(it);
  endtask

  // Lowers valid and waits until every expected result has come back. Each
  // item yields exactly one result, so no result is in flight at that point.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input logic fast, input logic [7:0] rt, input logic [11:0] tt);
    write_reg(CFG_CLOCK_FAST, {11'd0, fast});
    write_reg(CFG_RESPONSE_TRIES, {4'd0, rt});
    write_reg(CFG_TOKEN_TRIES, tt);
    cfg_we <= 1'b0;
  endtask

  // Runs one transaction from its start item. The card answers each exchange
  // according to the predicted phase: it waits a few polls before answering,
  // returns the read CRC, flipped under a fault, accepts or rejects writes and stays busy
  // for a while. A stop count above zero abandons the transaction early so
  // that the next start arrives while the sequencer is busy.
  task automatic run_transaction(input item_t start, input fault_t fault, input int stop_after);
    item_t       it;
    logic [15:0] sent_crc;
    logic [7:0]  v;
    int          rt_eff;
    int          tt_eff;
    int          resp_wait;
    int          tok_wait;
    int          dresp_wait;
    int          busy_wait;
    int          waited;
    int          steps;
    rt_eff = (sb.resp_tries == 0) ? 1 : sb.resp_tries;
    tt_eff = (sb.token_tries == 0) ? 1 : sb.token_tries;
    if (rt_eff <= 20 && $urandom_range(3) == 0) resp_wait = rt_eff - 1;
    else resp_wait = $urandom_range(0, (rt_eff - 1 < 3) ? rt_eff - 1 : 3);
    if (tt_eff <= 40 && $urandom_range(3) == 0) tok_wait = tt_eff - 1;
    else tok_wait = $urandom_range(0, (tt_eff - 1 < 4) ? tt_eff - 1 : 4);
    dresp_wait = $urandom_range(3);
    busy_wait  = ($urandom_range(7) == 0) ? $urandom_range(20) : $urandom_range(4);
    sent_crc   = '0;
    waited     = 0;
    steps      = 0;

    send_item(start);
    while (sb.phase != PH_IDLE && (stop_after <= 0 || steps < stop_after)) begin
      it = random_item();
      it.command = CMD_XCHG;
      // A few exchanges carry a raw random byte whatever the phase.
      if ($urandom_range(99) >= 3) begin
        case (sb.phase)
          PH_RESP: begin
            if (fault == F_NO_RESP || sb.tries < resp_wait) begin
              it.miso = BYTE_IDLE;
            end else if ($urandom_range(1)) begin
              it.miso = {7'd0, 1'($urandom)};
            end else begin
              it.miso = 8'($urandom_range(254));
            end
          end
          PH_TOKEN: begin
            if (fault == F_NO_TOKEN || sb.tries < tok_wait) begin
              if ($urandom_range(3) != 0) begin
                it.miso = BYTE_IDLE;
              end else begin
                do v = 8'($urandom); while (v == BYTE_START_TOKEN);
                it.miso = v;
              end
            end else begin
              it.miso = BYTE_START_TOKEN;
            end
          end
          PH_CRC_IN: begin
            // The card sends the data CRC, high byte first; a bad CRC flips
            // one bit of it.
            if (sb.count == 10'd0) begin
              sent_crc = sb.crc16 ^ ((fault == F_BAD_CRC) ?
                                     16'(1 << $urandom_range(15)) : 16'd0);
              it.miso  = sent_crc[15:8];
            end else begin
              it.miso = sent_crc[7:0];
            end
          end
          PH_DRESP: begin
            if (waited < dresp_wait) begin
              it.miso = BYTE_IDLE;
              waited++;
            end else begin
              if (fault == F_REJECT) begin
                do v = 8'($urandom_range(254)); while (v[4:0] == DRESP_MASK_OK);
                it.miso = v;
              end else begin
                it.miso = {3'($urandom), DRESP_MASK_OK};
              end
              waited = 0;
            end
          end
          PH_BUSY: begin
            if (waited < busy_wait) begin
              it.miso = BYTE_BUSY;
              waited++;
            end else begin
              it.miso = $urandom_range(1) ? BYTE_IDLE : 8'($urandom_range(1, 255));
            end
          end
          default: ;
        endcase
      end
      send_item(it);
      steps++;
    end
  endtask

  task automatic random_transaction();
    item_t  start;
    item_t  stray;
    fault_t f;
    int     roll;
    int     stop;
    start = random_item();
    start.command = cmd_t'(2'($urandom_range(2)));
    start.rlen    = 3'($urandom_range(7));
    start.blen    = ($urandom_range(59) == 0) ? 10'($urandom_range(1023))
                                              : 10'($urandom_range(16));
    roll = $urandom_range(99);
    f = F_NONE;
    if (roll < 6) begin
      f = F_NO_RESP;
    end else if (roll < 14) begin
      if (start.command == CMD_READ && sb.token_tries <= 64) f = F_NO_TOKEN;
      else if (start.command == CMD_WRITE) f = F_REJECT;
    end else if (roll < 22 && start.command == CMD_READ) begin
      f = F_BAD_CRC;
    end
    stop = ($urandom_range(19) == 0) ? $urandom_range(1, 12) : 0;
    // Now and then an exchange arrives while nothing is running.
    if (sb.phase == PH_IDLE && $urandom_range(24) == 0) begin
      stray = random_item();
      stray.command = CMD_XCHG;
      send_item(stray);
    end
    run_transaction(start, f, stop);
  endtask

  initial begin
    item_t it;
    int    p;
    sb = new();
    calm        = 1'b0;
    cycle_count = 0;
    n_items     = 0;
    n_idle      = 0;
    foreach (n_starts[i]) n_starts[i] = 0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_CLOCK_FAST;
    cfg_data           <= '0;
    in_valid           <= 1'b0;
    in_command         <= CMD_PLAIN;
    in_cmd_index       <= '0;
    in_argument        <= '0;
    in_response_length <= '0;
    in_block_length    <= '0;
    in_miso_byte       <= '0;
    in_write_byte      <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under the reset configuration. First an exchange with
    // nothing running, which must come back with no byte to send.
    it = random_item();
    it.command = CMD_XCHG;
    send_item(it);

    // Highest index and an all-ones argument with a response length above
    // range, abandoned after two exchanges by the next start.
    it = random_item();
    it.command   = CMD_PLAIN;
    it.cmd_index = 6'h3F;
    it.argument  = 32'hFFFF_FFFF;
    it.rlen      = 3'd7;
    run_transaction(it, F_NONE, 2);

    // Command zero with a zero argument and a response length of zero.
    it = random_item();
    it.command   = CMD_PLAIN;
    it.cmd_index = 6'h00;
    it.argument  = 32'h0000_0000;
    it.rlen      = 3'd0;
    run_transaction(it, F_NONE, 0);

    // A read of length zero, which runs as a single data byte.
    it = random_item();
    it.command = CMD_READ;
    it.blen    = 10'd0;
    run_transaction(it, F_NONE, 0);

    // Random part in phases, each under its own register setting: minimum
    // tries, zero tries, the defaults at full rate, maximum tries with the
    // longest block, then random small settings.
    p = 0;
    while (n_items < ITEM_GOAL) begin
      drain();
      case (p)
        0:       configure(1'b1, 8'd1, 12'd1);
        1:       configure(1'b1, 8'd0, 12'd0);
        2:       configure(1'b0, RESP_TRIES_RST, TOKEN_TRIES_RST);
        3:       configure(1'b0, 8'd255, 12'd4095);
        default: configure(1'($urandom), 8'($urandom_range(1, 20)), 12'($urandom_range(1, 40)));
      endcase
      calm = (p == 2);
      if (p == 3) begin
        // The longest block: a write whose length is clamped to the maximum.
        it = random_item();
        it.command = CMD_WRITE;
        it.blen    = 10'd1023;
        run_transaction(it, F_NONE, 0);
      end
      for (int t = 0; t < 12 && n_items < ITEM_GOAL; t++) random_transaction();
      p++;
    end

    drain();
    calm = 1'b0;
    repeat (4) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0d expected results never arrived.", sb.pending());
    end

    $display("Run covered %0d items (%0d plain, %0d read, %0d write starts)",
             n_items, n_starts[CMD_PLAIN], n_starts[CMD_READ], n_starts[CMD_WRITE]);
    $display("and %0d idle exchanges. Endings: %0d ok, %0d no response, %0d no token,",
             n_idle, sb.endings[ST_OK], sb.endings[ST_NO_RESP], sb.endings[ST_NO_TOKEN]);
    $display("%0d bad CRC, %0d rejected; %0d errors.",
             sb.endings[ST_CRC_ERR], sb.endings[ST_REJECTED], sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
